>>> rtl/hisp_pkg.sv
// Shared types, constants and the hex digit decoder for the hex identifier parser.
package hisp_pkg;

  // Identifier geometry
  localparam int unsigned ID_BYTES   = 17;
  localparam int unsigned UUID_BYTES = 16;
  localparam int unsigned IDX_W      = 5;

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(ID_BYTES - 1);
  localparam logic [IDX_W-1:0] FULL_CNT   = IDX_W'(ID_BYTES);
  localparam logic [IDX_W-1:0] SHORT_CNT  = IDX_W'(UUID_BYTES);

  // Character codes
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;

  // Register reset values
  localparam logic [7:0] SGTIN_HDR_RST = 8'd48;
  localparam logic [7:0] GID_HDR_RST   = 8'd53;

  // Input action codes
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Identifier type codes
  typedef enum logic [2:0] {
    TYPE_UNDEFINED = 3'd0,
    TYPE_UUID      = 3'd1,
    TYPE_SGTIN     = 3'd2,
    TYPE_GID       = 3'd3,
    TYPE_OTHER     = 3'd4
  } id_type_t;

  // Controller states
  typedef enum logic {
    ST_PARSE = 1'b0,
    ST_EMIT  = 1'b1
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic take_char;
    logic end_str;
    logic out_taken;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last_item;
  } status_t;

  // Decoded hex digit
  typedef struct packed {
    logic       bad;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] ch);
    hex_t h;
    logic [7:0] d;
    h.bad = 1'b0;
    h.nib = 4'd0;
    d     = 8'd0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      d = ch - CH_ZERO;
    end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
      d = ch - CH_UP_A + 8'd10;
    end else if (ch >= CH_LO_A && ch <= CH_LO_F) begin
      d = ch - CH_LO_A + 8'd10;
    end else begin
      h.bad = 1'b1;
    end
    h.nib = d[3:0];
    return h;
  endfunction

endpackage

>>> rtl/hisp_regs.sv
// Configuration register block: header values behind an APB-style port.
module hisp_regs (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready,
  output logic [7:0] sgtin_hdr,
  output logic [7:0] gid_hdr
);
  import hisp_pkg::*;

  logic [7:0] sgtin_hdr_r, sgtin_hdr_nxt;
  logic [7:0] gid_hdr_r, gid_hdr_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Decode the word address of a write
  always_comb begin
    sgtin_hdr_nxt = sgtin_hdr_r;
    gid_hdr_nxt   = gid_hdr_r;
    if (wr_en) begin
      if (paddr[2]) begin
        gid_hdr_nxt = pwdata[7:0];
      end else begin
        sgtin_hdr_nxt = pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sgtin_hdr_r <= SGTIN_HDR_RST;
      gid_hdr_r   <= GID_HDR_RST;
    end else begin
      sgtin_hdr_r <= sgtin_hdr_nxt;
      gid_hdr_r   <= gid_hdr_nxt;
    end
  end

  // Read back
  assign prdata    = {24'd0, paddr[2] ? gid_hdr_r : sgtin_hdr_r};
  assign sgtin_hdr = sgtin_hdr_r;
  assign gid_hdr   = gid_hdr_r;

endmodule

>>> rtl/hisp_ctrl.sv
// Controller state machine: parse phase and byte emission phase.
module hisp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_action,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output hisp_pkg::cmd_t    cmd,
  input  hisp_pkg::status_t status
);
  import hisp_pkg::*;

  state_t state_r, state_nxt;
  logic   in_acc;
  logic   out_acc;

  assign in_acc  = in_valid & ~in_stall;
  assign out_acc = out_valid & ~out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_PARSE: begin
        if (in_acc && in_action == ACT_END) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc && status.last_item) state_nxt = ST_PARSE;
      end
      default: state_nxt = ST_PARSE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PARSE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Outputs and datapath commands
  always_comb begin
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    cmd.take_char = 1'b0;
    cmd.end_str   = 1'b0;
    cmd.out_taken = 1'b0;
    case (state_r)
      ST_PARSE: begin
        in_stall      = 1'b0;
        cmd.take_char = in_valid & (in_action == ACT_CHAR);
        cmd.end_str   = in_valid & (in_action == ACT_END);
      end
      ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.out_taken = ~out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/hisp_dp.sv
// Datapath: hex decode, byte store, end-of-string check, classification and emit.
module hisp_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  hisp_pkg::cmd_t    cmd,
  output hisp_pkg::status_t status,
  input  logic [7:0]       character,
  input  logic [7:0]       sgtin_hdr,
  input  logic [7:0]       gid_hdr,
  output logic             valid_res,
  output logic [2:0]       id_type,
  output logic [4:0]       byte_index,
  output logic [7:0]       byte_value,
  output logic             last
);
  import hisp_pkg::*;

  // Byte store: written at the fill count, read at the emit index
  logic [7:0] store_r [ID_BYTES];

  logic [IDX_W-1:0] count_r, count_nxt;
  logic [3:0]       high_r, high_nxt;
  logic             expect_r, expect_nxt;
  logic             dash_r, dash_nxt;
  logic             stop_r, stop_nxt;
  logic             ok_r, ok_nxt;
  logic             short_r, short_nxt;
  id_type_t         type_r, type_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  hex_t       hex;
  logic       wr_en;
  logic [7:0] wr_byte;
  logic       mid_zero;
  id_type_t   cls;

  assign hex     = hex_decode(character);
  assign wr_byte = {high_r, hex.nib};

  // Classify from bytes 0 and 6..9
  assign mid_zero = (store_r[6] == 8'd0) && (store_r[7] == 8'd0) &&
                    (store_r[8] == 8'd0) && (store_r[9] == 8'd0);
  always_comb begin
    if (!mid_zero) begin
      cls = TYPE_UUID;
    end else if (store_r[0] == sgtin_hdr) begin
      cls = TYPE_SGTIN;
    end else if (store_r[0] == gid_hdr) begin
      cls = TYPE_GID;
    end else begin
      cls = TYPE_OTHER;
    end
  end

  // Parse and emit bookkeeping
  always_comb begin
    count_nxt  = count_r;
    high_nxt   = high_r;
    expect_nxt = expect_r;
    dash_nxt   = dash_r;
    stop_nxt   = stop_r;
    ok_nxt     = ok_r;
    short_nxt  = short_r;
    type_nxt   = type_r;
    idx_nxt    = idx_r;
    wr_en      = 1'b0;
    if (cmd.take_char && !stop_r) begin
      if (character == CH_DASH) begin
        dash_nxt = 1'b1;
      end else if (hex.bad) begin
        stop_nxt = 1'b1;
      end else if (!expect_r) begin
        high_nxt   = hex.nib;
        expect_nxt = 1'b1;
      end else begin
        wr_en      = 1'b1;
        count_nxt  = count_r + 1'b1;
        expect_nxt = 1'b0;
        if (count_r == LAST_IDX) stop_nxt = 1'b1;
      end
    end
    if (cmd.end_str) begin
      // Latch the verdict and clear the string state
      ok_nxt     = (count_r == FULL_CNT) || (dash_r && count_r == SHORT_CNT);
      short_nxt  = (count_r == SHORT_CNT);
      type_nxt   = cls;
      idx_nxt    = '0;
      count_nxt  = '0;
      high_nxt   = 4'd0;
      expect_nxt = 1'b0;
      dash_nxt   = 1'b0;
      stop_nxt   = 1'b0;
    end
    if (cmd.out_taken) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      high_r   <= 4'd0;
      expect_r <= 1'b0;
      dash_r   <= 1'b0;
      stop_r   <= 1'b0;
      ok_r     <= 1'b0;
      short_r  <= 1'b0;
      type_r   <= TYPE_UNDEFINED;
      idx_r    <= '0;
    end else begin
      count_r  <= count_nxt;
      high_r   <= high_nxt;
      expect_r <= expect_nxt;
      dash_r   <= dash_nxt;
      stop_r   <= stop_nxt;
      ok_r     <= ok_nxt;
      short_r  <= short_nxt;
      type_r   <= type_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // Store the completed byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[count_r] <= wr_byte;
    end
  end

  // Present the current result; the short form reads zero in its last byte
  assign status.last_item = ~ok_r | (idx_r == LAST_IDX);
  assign valid_res  = ok_r;
  assign id_type    = ok_r ? type_r : TYPE_UNDEFINED;
  assign byte_index = ok_r ? idx_r : '0;
  assign byte_value = (!ok_r || (short_r && idx_r == LAST_IDX)) ? 8'd0 : store_r[idx_r];
  assign last       = status.last_item;

endmodule

>>> rtl/hex_id_string_parser_core.sv
// Hex identifier string parser: characters in one per cycle while parsing.
// An end-of-string request is followed by 17 results for a valid
// identifier, or one for an invalid one, while the input is stalled; the
// emit index walks the byte store one byte per accepted result.
// Headers are written through the APB-style port at addresses 0 and 4.
module hex_id_string_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_character,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_valid_res,
  output logic [2:0]  out_id_type,
  output logic [4:0]  out_byte_index,
  output logic [7:0]  out_byte_value,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hisp_pkg::*;

  cmd_t       cmd;
  status_t    status;
  logic [7:0] sgtin_hdr;
  logic [7:0] gid_hdr;

  hisp_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .sgtin_hdr (sgtin_hdr),
    .gid_hdr   (gid_hdr)
  );

  hisp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  hisp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .character  (in_character),
    .sgtin_hdr  (sgtin_hdr),
    .gid_hdr    (gid_hdr),
    .valid_res  (out_valid_res),
    .id_type    (out_id_type),
    .byte_index (out_byte_index),
    .byte_value (out_byte_value),
    .last       (out_last)
  );

endmodule

>>> rtl/hisp_chk.sv
// Port-level checker for the hex identifier parser, bound to the top level.
module hisp_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_valid_res,
  input logic [2:0] out_id_type,
  input logic [4:0] out_byte_index,
  input logic [7:0] out_byte_value,
  input logic       out_last
);
  import hisp_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte_index) &&
      $stable(out_byte_value) && $stable(out_last) && $stable(out_id_type))
    else $error("stalled result changed");

  // Take no request while results are pending
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during emission");

  // An invalid result is a single all-zero final result
  a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_last && out_id_type == TYPE_UNDEFINED &&
      out_byte_index == 5'd0 && out_byte_value == 8'd0)
    else $error("malformed invalid result");

  // The final byte of a valid identifier sits at the last index
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> (out_last == (out_byte_index == LAST_IDX)))
    else $error("last flag out of place");

  // Drop valid after the final result is taken
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last |=> !out_valid)
    else $error("results continue after final one");

endmodule

bind hex_id_string_parser_core hisp_chk u_hisp_chk (.*);

>>> tb/sv/hisp_tb_pkg.sv
// Register indexes and address stride of the hex identifier parser header port.
package hisp_tb_pkg;

  localparam int unsigned REG_SGTIN_HDR = 0;
  localparam int unsigned REG_GID_HDR   = 1;
  localparam int unsigned REG_STRIDE    = 4;

endpackage

>>> tb/sv/hex_id_string_parser_core_checker.sv
// Checker for the hex identifier parser: tracks header writes, predicts and compares results.
module hex_id_string_parser_core_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_character,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_valid_res,
  input  logic [2:0]  out_id_type,
  input  logic [4:0]  out_byte_index,
  input  logic [7:0]  out_byte_value,
  input  logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          results_due
);
  import hisp_pkg::*;
  import hisp_tb_pkg::*;

  typedef struct packed {
    logic       valid_res;
    id_type_t   id_type;
    logic [4:0] byte_index;
    logic [7:0] byte_value;
    logic       last;
  } id_byte_t;

  // Results still owed by the block, oldest first
  id_byte_t   id_bytes_due[$];

  // Parser state of the current string
  logic [7:0] id_store [ID_BYTES];
  logic [4:0] bytes_stored;
  logic [3:0] high_nib;
  logic       low_next;
  logic       dash_seen;
  logic       parse_stopped;

  // Header registers as last written
  logic [7:0] sgtin_hdr;
  logic [7:0] gid_hdr;

  int errors = 0;

  // Nibble value of a hex digit, -1 for anything else
  function automatic int hex_nibble(input logic [7:0] ch);
    if (ch >= CH_ZERO && ch <= CH_NINE) return int'(ch) - int'(CH_ZERO);
    if (ch >= CH_UP_A && ch <= CH_UP_F) return int'(ch) - int'(CH_UP_A) + 10;
    if (ch >= CH_LO_A && ch <= CH_LO_F) return int'(ch) - int'(CH_LO_A) + 10;
    return -1;
  endfunction

  task automatic clear_string();
    foreach (id_store[k]) id_store[k] = 8'h00;
    bytes_stored  = '0;
    high_nib      = '0;
    low_next      = 1'b0;
    dash_seen     = 1'b0;
    parse_stopped = 1'b0;
  endtask

  task automatic note_failure(input string what);
    errors++;
    if (errors <= 10) $display("[%0t] checker: %s", $realtime, what);
  endtask

  // Advance the parser by one request, queue the results of an end of string
  task automatic parse_request(input logic act, input logic [7:0] ch);
    int       nib;
    logic     full;
    id_type_t kind;
    id_byte_t r;
    if (act == ACT_CHAR) begin
      nib = hex_nibble(ch);
      if (parse_stopped) begin
        // drop everything after a stop, dashes too
      end else if (ch == CH_DASH) begin
        dash_seen = 1'b1;
      end else if (nib < 0) begin
        parse_stopped = 1'b1;
      end else if (!low_next) begin
        high_nib = nib[3:0];
        low_next = 1'b1;
      end else begin
        id_store[bytes_stored] = {high_nib, nib[3:0]};
        bytes_stored = bytes_stored + 5'd1;
        low_next = 1'b0;
        if (bytes_stored == FULL_CNT) parse_stopped = 1'b1;
      end
    end else begin
      full = (bytes_stored == FULL_CNT) || (dash_seen && bytes_stored == SHORT_CNT);
      if (!full) begin
        r.valid_res  = 1'b0;
        r.id_type    = TYPE_UNDEFINED;
        r.byte_index = '0;
        r.byte_value = '0;
        r.last       = 1'b1;
        id_bytes_due.push_back(r);
      end else begin
        // short dashed form: the final byte reads as zero
        if (bytes_stored == SHORT_CNT) id_store[ID_BYTES-1] = 8'h00;
        if (id_store[6] == 0 && id_store[7] == 0 && id_store[8] == 0 && id_store[9] == 0) begin
          if (id_store[0] == sgtin_hdr) kind = TYPE_SGTIN;
          else if (id_store[0] == gid_hdr) kind = TYPE_GID;
          else kind = TYPE_OTHER;
        end else begin
          kind = TYPE_UUID;
        end
        for (int k = 0; k < ID_BYTES; k++) begin
          r.valid_res  = 1'b1;
          r.id_type    = kind;
          r.byte_index = 5'(k);
          r.byte_value = id_store[k];
          r.last       = (k == ID_BYTES - 1);
          id_bytes_due.push_back(r);
        end
      end
      clear_string();
    end
  endtask

  // Compare one accepted result with the oldest expectation
  task automatic check_result();
    id_byte_t exp;
    if (id_bytes_due.size() == 0) begin
      note_failure($sformatf("unexpected result valid=%0b type=%0d idx=%0d byte=%02h last=%0b",
                             out_valid_res, out_id_type, out_byte_index, out_byte_value,
                             out_last));
    end else begin
      exp = id_bytes_due.pop_front();
      if (out_valid_res !== exp.valid_res || out_id_type !== exp.id_type ||
          out_byte_index !== exp.byte_index || out_byte_value !== exp.byte_value ||
          out_last !== exp.last) begin
        note_failure($sformatf(
          "expected valid=%0b type=%0d idx=%0d byte=%02h last=%0b, got %0b %0d %0d %02h %0b",
          exp.valid_res, exp.id_type, exp.byte_index, exp.byte_value, exp.last,
          out_valid_res, out_id_type, out_byte_index, out_byte_value, out_last));
      end
    end
  endtask

  // Watch the header port and both channels
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_string();
      sgtin_hdr = SGTIN_HDR_RST;
      gid_hdr   = GID_HDR_RST;
      id_bytes_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'(REG_SGTIN_HDR * REG_STRIDE)) sgtin_hdr = pwdata[7:0];
        else if (paddr == 3'(REG_GID_HDR * REG_STRIDE)) gid_hdr = pwdata[7:0];
      end
      if (in_valid && !in_stall) parse_request(in_action, in_character);
      if (out_valid && !out_stall) check_result();
    end
    results_due <= id_bytes_due.size();
    fail_count  <= errors;
  end

endmodule

>>> tb/sv/hex_id_string_parser_core_tb.sv
// Top of the hex identifier parser testbench: clock, reset, stimulus and verdict.
module hex_id_string_parser_core_tb;
  import hisp_pkg::*;
  import hisp_tb_pkg::*;

  localparam int PHASE_ITEMS = 78;
  localparam int DIRECTED    = 23;
  localparam int SETTLE      = 8;
  localparam int LIMIT       = 200000;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic        in_action    = ACT_CHAR;
  logic [7:0]  in_character = 8'h00;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic        out_valid_res;
  logic [2:0]  out_id_type;
  logic [4:0]  out_byte_index;
  logic [7:0]  out_byte_value;
  logic        out_last;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  int         fail_count;
  int         results_due;
  int         cycles     = 0;
  int         items_done = 0;
  int         stall_left = 0;
  bit         idle_on    = 1'b1;
  bit         stall_on   = 1'b1;
  logic [7:0] cur_sgtin  = SGTIN_HDR_RST;
  logic [7:0] cur_gid    = GID_HDR_RST;

  hex_id_string_parser_core u_dut (.*);

  hex_id_string_parser_core_checker u_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result channel in short random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_on && !out_stall && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("hex_id_string_parser_core: mismatch");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
    if (v < 4'd10) return CH_ZERO + 8'(v);
    return (lower ? CH_LO_A : CH_UP_A) + 8'(v) - 8'd10;
  endfunction

  // Present one request and hold it until the block takes it
  task automatic send_request(input logic act, input logic [7:0] ch);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_character <= ch;
    do @(posedge clk); while (in_stall);
    items_done++;
  endtask

  task automatic end_string();
    send_request(ACT_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(ACT_CHAR, s[i]);
  endtask

  // Drop valid, then hold until every result has come and the block has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_header(input int unsigned idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * REG_STRIDE);
    pwdata  <= {24'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == REG_SGTIN_HDR) cur_sgtin = val;
    else cur_gid = val;
  endtask

  // Send an identifier as hex text; a nonnegative cut keeps only that many digits
  task automatic send_identifier(input int n_bytes, input bit dashed, input int cut);
    logic [7:0] id [ID_BYTES];
    logic [3:0] v;
    int         flavor;
    int         n_nib;
    int         junk;
    bit         placed;
    foreach (id[k]) id[k] = 8'($urandom);
    flavor = $urandom_range(0, 4);
    if (flavor <= 2) begin
      for (int k = 6; k <= 9; k++) id[k] = 8'h00;
      if (flavor == 0) id[0] = cur_sgtin;
      else if (flavor == 1) id[0] = cur_gid;
    end
    n_nib  = (cut < 0) ? 2 * n_bytes : cut;
    placed = 1'b0;
    for (int i = 0; i < n_nib; i++) begin
      // dashes at the usual group breaks, now and then elsewhere
      if (dashed && (((i == 8 || i == 12 || i == 16 || i == 20) &&
                      ($urandom_range(0, 1) == 1 || (i == 20 && !placed))) ||
                     $urandom_range(0, 39) == 0)) begin
        send_request(ACT_CHAR, CH_DASH);
        placed = 1'b1;
      end
      v = (i % 2 == 0) ? id[i/2][7:4] : id[i/2][3:0];
      send_request(ACT_CHAR, hex_char(v, 1'($urandom_range(0, 1))));
    end
    if (cut >= 0 && $urandom_range(0, 1) == 1) begin
      send_request(ACT_CHAR, 8'($urandom_range(0, 255)));
    end
    // trailing characters after a full identifier are ignored by the block
    if (cut < 0 && n_bytes == ID_BYTES && $urandom_range(0, 3) == 0) begin
      junk = $urandom_range(1, 3);
      repeat (junk) send_request(ACT_CHAR, 8'($urandom_range(0, 255)));
    end
    end_string();
  endtask

  initial begin
    int         pick;
    int         n;
    logic [7:0] hdr;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty string, NUL, gap between digits and letters, both cases,
    // dashes after a stop, dangling high nibble, top code, other stop characters
    end_string();
    send_request(ACT_CHAR, 8'h00);
    end_string();
    send_text("9:A");
    end_string();
    send_text("aF-G-");
    end_string();
    send_text("fF0");
    end_string();
    send_request(ACT_CHAR, 8'hFF);
    end_string();
    send_text("/`g");
    end_string();
    wait_idle();

    // Random phases, one header setting each
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin
          write_header(REG_SGTIN_HDR, 8'h00);
          write_header(REG_GID_HDR, 8'hFF);
        end
        2: begin
          write_header(REG_SGTIN_HDR, 8'hFF);
          write_header(REG_GID_HDR, 8'h00);
        end
        3: begin
          hdr = 8'($urandom);
          write_header(REG_SGTIN_HDR, hdr);
          write_header(REG_GID_HDR, hdr);
        end
        4: begin
          write_header(REG_SGTIN_HDR, 8'($urandom));
          write_header(REG_GID_HDR, 8'($urandom));
          idle_on = 1'b0;
          stall_on <= 1'b0;
        end
        default: begin
        end
      endcase
      while (items_done < DIRECTED + (phase + 1) * PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick <= 2) begin
          send_identifier(ID_BYTES, 1'($urandom_range(0, 1)), -1);
        end else if (pick <= 5) begin
          send_identifier(UUID_BYTES, 1'b1, -1);
        end else if (pick == 6) begin
          send_identifier(ID_BYTES, 1'($urandom_range(0, 1)), $urandom_range(0, 33));
        end else if (pick == 7) begin
          send_identifier(UUID_BYTES, 1'b0, -1);
        end else begin
          n = $urandom_range(1, 6);
          repeat (n) send_request(ACT_CHAR, 8'($urandom_range(0, 255)));
          end_string();
        end
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("hex_id_string_parser_core: match");
    end else begin
      $display("hex_id_string_parser_core: mismatch");
    end
    $finish;
  end

endmodule
